@@ rtl/smfd_pkg.sv @@
// Shared constants and types for the stereo-to-mono FIR decimator.
`default_nettype none

package smfd_pkg;

    localparam int MAX_TAPS       = 64;
    localparam int MAX_DECIMATION = 16;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_IDX_W = 6;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);

    localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PHASE_W    = $clog2(MAX_DECIMATION);
    localparam int DEC_CNT_W  = $clog2(MAX_DECIMATION + 1);
    localparam int IDX_CMP_W  = (TAP_IDX_W > COEF_IDX_W) ? TAP_IDX_W : COEF_IDX_W;

    localparam int DEC_REG_W  = 5;
    localparam int TAPS_REG_W = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DEC_REG_W-1:0]  DEC_RST  = 5'd4;
    localparam logic [TAPS_REG_W-1:0] TAPS_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 2'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;
        logic rotate;
        logic coef_write;
    } cell_ctrl_t;

    // Control of the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic enable;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/smfd_cell.sv @@
// One cell of the chain: a history sample and the tap that weights it.
`default_nettype none

module smfd_cell
    import smfd_pkg::*;
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire cell_ctrl_t                   ctrl,
    input  wire logic [IDX_CMP_W-1:0]         cell_index,
    input  wire logic signed [SAMPLE_W-1:0]   hist_shift_in,
    input  wire logic signed [SAMPLE_W-1:0]   hist_rot_in,
    input  wire logic signed [SAMPLE_W-1:0]   tap_rot_in,
    input  wire logic [COEF_IDX_W-1:0]        coef_index,
    input  wire logic signed [SAMPLE_W-1:0]   coef_value,
    output logic signed [SAMPLE_W-1:0]        hist_out,
    output logic signed [SAMPLE_W-1:0]        tap_out
);

    logic signed [SAMPLE_W-1:0] hist_reg;
    logic signed [SAMPLE_W-1:0] tap_reg;
    logic                       index_match;

    assign index_match = (IDX_CMP_W'(coef_index) == cell_index);

    // Rotation moves both rings one place towards cell 0; a full lap restores them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            tap_reg  <= '0;
        end
        else if (ctrl.rotate)
        begin
            hist_reg <= hist_rot_in;
            tap_reg  <= tap_rot_in;
        end
        else
        begin
            if (ctrl.shift)
            begin
                hist_reg <= hist_shift_in;
            end
            if (ctrl.coef_write && index_match)
            begin
                tap_reg <= coef_value;
            end
        end
    end

    assign hist_out = hist_reg;
    assign tap_out  = tap_reg;

endmodule

`default_nettype wire

@@ rtl/smfd_mac.sv @@
// Multiply-accumulate unit with Q15 rounding and saturation of the sum.
`default_nettype none

module smfd_mac
    import smfd_pkg::*;
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire mac_ctrl_t                   ctrl,
    input  wire logic signed [SAMPLE_W-1:0]  tap,
    input  wire logic signed [SAMPLE_W-1:0]  hist,
    output logic signed [SAMPLE_W-1:0]       result
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  bias;
    logic signed [ACC_W-1:0]  rounded;
    logic [ACC_W-1-(PROD_W-2):0] upper;
    logic                     fits;

    always_ff @(posedge clk)
    begin
        prod_reg <= tap * hist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else if (ctrl.clear)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.enable;
            if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Half away from zero: a negative sum takes one less than half before the floor shift.
    assign bias    = acc_reg[ACC_W-1] ? ACC_W'(16383) : ACC_W'(16384);
    assign rounded = acc_reg + bias;

    // The quotient fits 16 bits when every bit from bit 30 upwards matches the sign.
    assign upper = rounded[ACC_W-1:PROD_W-2];
    assign fits  = (upper == '0) || (upper == '1);

    assign result = fits ? rounded[PROD_W-2:SAMPLE_W-1]
                         : (rounded[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

endmodule

`default_nettype wire

@@ rtl/stereo_to_mono_fir_decimator_core.sv @@
// Top level of the stereo-to-mono FIR decimator: control, cell chain and MAC.
`default_nettype none

// A coefficient write, or a stereo pair that does not complete a decimation
// period, is taken and leaves the block ready for the next item. A pair that
// completes the period starts a pass in which the history and tap rings
// rotate one full lap (MAX_TAPS places) through the cell chain, feeding cell 0
// into the single multiply-accumulate unit; a drain step and a rounding step
// follow, and the block takes no new item until it has left the rounding step.
// The rounded result waits in an output register, and the block only stalls
// at the rounding step if that register is still full. Reset clears the
// history, taps and phase at once; no clearing pass.
module stereo_to_mono_fir_decimator_core
    import smfd_pkg::*;
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic signed [SAMPLE_W-1:0]   left_sample,
    input  wire logic signed [SAMPLE_W-1:0]   right_sample,
    input  wire logic [COEF_IDX_W-1:0]        coef_index,
    input  wire logic signed [SAMPLE_W-1:0]   coef_value,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic signed [SAMPLE_W-1:0]        filtered_sample,
    input  wire                               cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [TAP_IDX_W-1:0]       step_reg, step_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [DEC_REG_W-1:0]       decimation_reg;
    logic [TAPS_REG_W-1:0]      taps_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;

    logic                       accept;
    logic                       sample_accept;
    logic                       coef_accept;
    logic [DEC_CNT_W-1:0]       dec_eff;
    logic [TAP_CNT_W-1:0]       taps_eff;
    logic [DEC_CNT_W-1:0]       phase_inc;
    logic                       fire;
    logic                       last_step;
    logic                       out_free;

    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   pair_adj;
    logic signed [SAMPLE_W-1:0] mono;

    cell_ctrl_t                 cell_ctrl;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] hist_w [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] tap_w  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] mac_result;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign sample_accept = accept && (command == CMD_SAMPLE);
    assign coef_accept   = accept && (command == CMD_COEF);
    assign out_free      = !out_valid_reg || out_ready;
    assign last_step     = (step_reg == TAP_IDX_W'(MAX_TAPS - 1));

    // Out-of-range register values are clamped into the supported range.
    always_comb
    begin
        if (decimation_reg == '0)
        begin
            dec_eff = DEC_CNT_W'(1);
        end
        else if (32'(decimation_reg) > MAX_DECIMATION)
        begin
            dec_eff = DEC_CNT_W'(MAX_DECIMATION);
        end
        else
        begin
            dec_eff = DEC_CNT_W'(decimation_reg);
        end

        if (taps_reg == '0)
        begin
            taps_eff = TAP_CNT_W'(1);
        end
        else if (32'(taps_reg) > MAX_TAPS)
        begin
            taps_eff = TAP_CNT_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TAP_CNT_W'(taps_reg);
        end
    end

    assign phase_inc = DEC_CNT_W'(phase_reg) + DEC_CNT_W'(1);
    assign fire      = (phase_inc >= dec_eff);

    // Average truncated toward zero: a negative sum is nudged up by one before the shift.
    assign pair_sum = {left_sample[SAMPLE_W-1], left_sample}
                    + {right_sample[SAMPLE_W-1], right_sample};
    assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    assign mono     = pair_adj[SAMPLE_W:1];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (sample_accept)
                begin
                    if (fire)
                    begin
                        phase_next = '0;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        phase_next = PHASE_W'(phase_inc);
                    end
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + TAP_IDX_W'(1);
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            phase_reg      <= '0;
            decimation_reg <= DEC_RST;
            taps_reg       <= TAPS_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DECIMATION:  decimation_reg <= cfg_data[DEC_REG_W-1:0];
                    REG_ACTIVE_TAPS: taps_reg       <= cfg_data[TAPS_REG_W-1:0];
                    default:         ;
                endcase
            end

            if ((state_reg == ST_ROUND) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ROUND) && out_free)
        begin
            filtered_reg <= mac_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = filtered_reg;

    assign cell_ctrl.shift      = sample_accept;
    assign cell_ctrl.rotate     = (state_reg == ST_MAC);
    assign cell_ctrl.coef_write = coef_accept;

    assign mac_ctrl.clear  = sample_accept && fire;
    assign mac_ctrl.enable = (state_reg == ST_MAC) && (TAP_CNT_W'(step_reg) < taps_eff);

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        smfd_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (cell_ctrl),
            .cell_index    (IDX_CMP_W'(i)),
            .hist_shift_in ((i == 0) ? mono : hist_w[(i + MAX_TAPS - 1) % MAX_TAPS]),
            .hist_rot_in   (hist_w[(i + 1) % MAX_TAPS]),
            .tap_rot_in    (tap_w[(i + 1) % MAX_TAPS]),
            .coef_index    (coef_index),
            .coef_value    (coef_value),
            .hist_out      (hist_w[i]),
            .tap_out       (tap_w[i])
        );
    end

    smfd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .tap    (tap_w[0]),
        .hist   (hist_w[0]),
        .result (mac_result)
    );

    a_fire_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && fire) |=> (state_reg == ST_MAC) && (step_reg == '0))
        else $error("completed decimation period did not start a filter pass");

    a_lap_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MAC) && last_step) |=> (state_reg == ST_DRAIN))
        else $error("rotation lap did not end in the drain step");

    a_round_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROUND) && out_free) |=> out_valid && (state_reg == ST_IDLE))
        else $error("rounded result was not presented");

    a_coef_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        coef_accept |=> $stable(phase_reg) && (state_reg == ST_IDLE))
        else $error("coefficient write disturbed the decimation phase");

endmodule

`default_nettype wire

@@ bench/stereo_to_mono_fir_decimator_core_tb.sv @@
// Self-checking testbench for the stereo-to-mono FIR decimator core.
`timescale 1ns / 100ps

module stereo_to_mono_fir_decimator_core_tb;
    import smfd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    localparam int N_PHASES      = 10;
    localparam int PHASE_ITEMS   = 93;
    localparam int MAX_GAP       = 60;
    localparam int MAX_FAIL_SHOW = 10;

    typedef struct {
        logic                        cmd;
        logic signed [SAMPLE_W-1:0]  left;
        logic signed [SAMPLE_W-1:0]  right;
        logic [COEF_IDX_W-1:0]       idx;
        logic signed [SAMPLE_W-1:0]  coef;
        bit                          typed;
        logic signed [SAMPLE_W-1:0]  want;
    } row_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0]  value;
        int                          item_no;
    } pending_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        command = CMD_SAMPLE;
    logic signed [SAMPLE_W-1:0]  left_sample = '0;
    logic signed [SAMPLE_W-1:0]  right_sample = '0;
    logic [COEF_IDX_W-1:0]       coef_index = '0;
    logic signed [SAMPLE_W-1:0]  coef_value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]  filtered_sample;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    // Own copy of the filter state and registers.
    logic signed [SAMPLE_W-1:0]  hist_model [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]  taps_model [MAX_TAPS];
    int                          phase_model;
    logic [DEC_REG_W-1:0]        dec_model;
    logic [TAPS_REG_W-1:0]       ntaps_model;

    pending_t                    pending_outputs [$];
    row_t                        directed_rows [$];
    idle_t                       idle_mode = IDLE_NONE;
    int                          fail_count = 0;
    int                          item_count = 0;
    int                          coef_count = 0;
    int                          result_count = 0;

    // Decimation and tap-count settings per phase; the eighth and ninth are drawn at random.
    logic [CFG_DATA_W-1:0] dec_plan [N_PHASES] =
        '{7'd1, 7'd16, 7'd0, 7'd31, 7'd16, 7'h63, 7'd2, 7'd0, 7'd0, 7'd5};
    logic [CFG_DATA_W-1:0] taps_plan [N_PHASES] =
        '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd33, 7'd0, 7'd0, 7'd64};

    stereo_to_mono_fir_decimator_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic reset_model();
        int k;
        for (k = 0; k < MAX_TAPS; k++)
        begin
            hist_model[k] = '0;
            taps_model[k] = '0;
        end
        phase_model = 0;
        dec_model   = DEC_RST;
        ntaps_model = TAPS_RST;
    endtask

    // Advances the filter state by one item; returns 1 when a decimated output falls due.
    function automatic bit filter_step(input row_t it, output logic signed [SAMPLE_W-1:0] y);
        int     mono;
        int     n_taps;
        int     n_dec;
        int     k;
        longint acc;
        longint mag;
        longint r;
        logic [31:0] mono_bits;
        logic [63:0] r_bits;
        y = '0;
        if (it.cmd == CMD_COEF)
        begin
            if (int'(it.idx) < MAX_TAPS)
                taps_model[it.idx] = it.coef;
            return 1'b0;
        end
        mono = (int'(it.left) + int'(it.right)) / 2;
        mono_bits = mono;
        for (k = MAX_TAPS - 1; k > 0; k--)
            hist_model[k] = hist_model[k-1];
        hist_model[0] = mono_bits[SAMPLE_W-1:0];

        n_dec = int'(dec_model);
        if (n_dec == 0)
            n_dec = 1;
        if (n_dec > MAX_DECIMATION)
            n_dec = MAX_DECIMATION;
        if (phase_model + 1 < n_dec)
        begin
            phase_model = phase_model + 1;
            return 1'b0;
        end
        phase_model = 0;

        n_taps = int'(ntaps_model);
        if (n_taps == 0)
            n_taps = 1;
        if (n_taps > MAX_TAPS)
            n_taps = MAX_TAPS;
        acc = 0;
        for (k = 0; k < n_taps; k++)
            acc += longint'(taps_model[k]) * longint'(hist_model[k]);

        // Round half away from zero on the magnitude, then clamp to Q15.
        mag = (acc < 0) ? -acc : acc;
        r = (mag + 16384) >>> 15;
        if (acc < 0)
        begin
            if (r > 32768)
                r = 32768;
            r = -r;
        end
        else if (r > 32767)
        begin
            r = 32767;
        end
        r_bits = r;
        y = r_bits[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_word();
        logic [31:0]                 tmp;
        logic signed [SAMPLE_W-1:0]  w;
        tmp = $urandom;
        w = tmp[SAMPLE_W-1:0];
        case ($urandom_range(9))
            0:       w = SAMPLE_MAX;
            1:       w = SAMPLE_MIN;
            2:       w = '0;
            3, 4, 5: ;
            default: w = w >>> $urandom_range(14);
        endcase
        return w;
    endfunction

    task automatic add_row(input logic cmd, input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r,
                           input logic [COEF_IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] coef,
                           input bit typed, input logic signed [SAMPLE_W-1:0] want);
        row_t it;
        it.cmd   = cmd;
        it.left  = l;
        it.right = r;
        it.idx   = idx;
        it.coef  = coef;
        it.typed = typed;
        it.want  = want;
        directed_rows.push_back(it);
    endtask

    task automatic random_row(output row_t it);
        logic [31:0] tmp;
        tmp = $urandom;
        it.cmd   = ($urandom_range(99) < 15) ? CMD_COEF : CMD_SAMPLE;
        it.left  = rand_word();
        it.right = rand_word();
        it.idx   = tmp[COEF_IDX_W-1:0];
        it.coef  = rand_word();
        it.typed = 1'b0;
        it.want  = '0;
    endtask

    // Presents one item, waits for it to be taken and records any output it causes.
    task automatic send_item(input row_t it);
        int                          gap;
        int                          pct;
        logic signed [SAMPLE_W-1:0]  y;
        pending_t                    p;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 76 : (idle_mode == IDLE_BOTH) ? 27 : 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= it.cmd;
        left_sample  <= it.left;
        right_sample <= it.right;
        coef_index   <= it.idx;
        coef_value   <= it.coef;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        item_count++;
        if (it.cmd == CMD_COEF)
            coef_count++;
        if (filter_step(it, y))
        begin
            p.value   = it.typed ? it.want : y;
            p.item_no = item_count;
            pending_outputs.push_back(p);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_DECIMATION)
            dec_model = data[DEC_REG_W-1:0];
        else if (idx == REG_ACTIVE_TAPS)
            ntaps_model = data[TAPS_REG_W-1:0];
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        pending_t head;
        int       stall;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_FAIL_SHOW)
                    $display("unexpected output %0d with nothing outstanding", filtered_sample);
            end
            else
            begin
                head = pending_outputs.pop_front();
                result_count++;
                if (filtered_sample !== head.value)
                begin
                    fail_count++;
                    if (fail_count <= MAX_FAIL_SHOW)
                        $display("output after item %0d: expected %0d, got %0d",
                                 head.item_no, head.value, filtered_sample);
                end
            end
        end
        stall = (idle_mode == IDLE_RECV) ? 76 : (idle_mode == IDLE_BOTH) ? 27 : 0;
        out_ready <= ($urandom_range(99) >= stall);
    end

    initial
    begin
        row_t                   it;
        logic [31:0]            tmp;
        logic [CFG_DATA_W-1:0]  dec_d;
        logic [CFG_DATA_W-1:0]  taps_d;
        int                     p;
        int                     n;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (one output per four pairs, all taps).
        // Taps are still zero after reset, so the first output must be zero.
        add_row(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 6'd63, -16'sd1, 1'b0, '0);
        add_row(CMD_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, 6'd0, SAMPLE_MAX, 1'b0, '0);
        add_row(CMD_SAMPLE, SAMPLE_MIN, SAMPLE_MAX, 6'd21, SAMPLE_MIN, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd1, 16'sd0, 6'd42, 16'sd0, 1'b1, 16'sd0);
        // A tap write ignores the sample fields.
        add_row(CMD_COEF, SAMPLE_MAX, SAMPLE_MIN, 6'd0, SAMPLE_MIN, 1'b0, '0);
        add_row(CMD_SAMPLE, 16'sd1, 16'sd1, 6'd5, 16'sd7, 1'b0, '0);
        add_row(CMD_SAMPLE, 16'sd1, 16'sd2, 6'd6, 16'sd8, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd3, 16'sd0, 6'd7, 16'sd9, 1'b0, '0);
        // Only tap 0 is set, so minus full scale squared clamps to the positive limit.
        add_row(CMD_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, 6'd8, 16'sd10, 1'b1, SAMPLE_MAX);
        add_row(CMD_COEF, 16'sh1234, -16'sh1234, 6'd1, SAMPLE_MIN, 1'b0, '0);
        add_row(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 6'd11, 16'sd0, 1'b0, '0);
        add_row(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 6'd12, 16'sd0, 1'b0, '0);
        add_row(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 6'd13, 16'sd0, 1'b0, '0);
        // Two taps at minus full scale against full-scale samples clamp to the negative limit.
        add_row(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, 6'd14, 16'sd0, 1'b1, SAMPLE_MIN);
        add_row(CMD_COEF, 16'sd0, 16'sd0, 6'd1, 16'sd0, 1'b0, '0);
        add_row(CMD_COEF, 16'sd0, 16'sd0, 6'd0, 16'sd1, 1'b0, '0);
        add_row(CMD_SAMPLE, 16'sd0, 16'sd0, 6'd0, 16'sd0, 1'b0, '0);
        add_row(CMD_SAMPLE, 16'sd0, 16'sd0, 6'd0, 16'sd0, 1'b0, '0);
        add_row(CMD_SAMPLE, 16'sd0, 16'sd0, 6'd0, 16'sd0, 1'b0, '0);
        // Exactly half an output step, which rounds away from zero.
        add_row(CMD_SAMPLE, 16'sd16384, 16'sd16384, 6'd0, 16'sd0, 1'b0, '0);
        add_row(CMD_COEF, 16'sd0, 16'sd0, 6'd63, SAMPLE_MAX, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd16384, -16'sd16384, 6'd33, -16'sd5, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd16384, -16'sd16384, 6'd34, -16'sd6, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd16384, -16'sd16384, 6'd35, -16'sd7, 1'b0, '0);
        add_row(CMD_SAMPLE, -16'sd16384, -16'sd16384, 6'd36, -16'sd8, 1'b0, '0);
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        for (p = 0; p < N_PHASES; p++)
        begin
            drain(80);
            dec_d  = dec_plan[p];
            taps_d = taps_plan[p];
            if (p == 7 || p == 8)
            begin
                tmp    = $urandom_range(31);
                dec_d  = tmp[CFG_DATA_W-1:0];
                tmp    = $urandom_range(127);
                taps_d = tmp[CFG_DATA_W-1:0];
            end
            tmp = $urandom;
            write_reg(REG_UNUSED_A, tmp[CFG_DATA_W-1:0]);
            write_reg(REG_DECIMATION, dec_d);
            write_reg(REG_ACTIVE_TAPS, taps_d);
            tmp = $urandom;
            write_reg(REG_UNUSED_B, tmp[CFG_DATA_W-1:0]);
            cfg_we <= 1'b0;
            idle_mode = idle_t'(p % 4);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_row(it);
                send_item(it);
            end
        end

        drain(100);
        fail_count += pending_outputs.size();
        $display("Sent %0d items (%0d tap writes) and checked %0d filter outputs.",
                 item_count, coef_count, result_count);
        $display("Covered %0d register settings, decimation 0..31 and taps 0..127, with gaps.",
                 N_PHASES + 1);
        if (fail_count == 0)
            $display("stereo_to_mono_fir_decimator_core: match");
        else
            $display("stereo_to_mono_fir_decimator_core: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d outputs outstanding", pending_outputs.size());
        $display("stereo_to_mono_fir_decimator_core: mismatch");
        $finish;
    end

endmodule
